// ----- hw/rtl/see_pkg.sv -----
// ----------------------------------------------------------------------------
// see_pkg: shared definitions for the stack expression evaluator
// Widths, depths, character codes, status codes and the sequencer states.
// ----------------------------------------------------------------------------
package see_pkg;

  localparam int STACK_DEPTH = 128;
  localparam int EXPR_MAX    = 128;

  localparam int TOKEN_W  = 8;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;

  localparam int SP_W  = $clog2(STACK_DEPTH + 1);
  localparam int SA_W  = $clog2(STACK_DEPTH);
  localparam int CNT_W = $clog2(EXPR_MAX + 1);
  localparam int BA_W  = $clog2(EXPR_MAX);
  localparam int DIV_CW = $clog2(VALUE_W);

  localparam logic [TOKEN_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [TOKEN_W-1:0] CH_NINE  = 8'h39;
  localparam logic [TOKEN_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [TOKEN_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [TOKEN_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [TOKEN_W-1:0] CH_SLASH = 8'h2F;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DIVZERO   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BUFFULL   = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_RD_TOP,
    S_RD_DEEP,
    S_OPER,
    S_DIV,
    S_WRITE,
    S_AFTER,
    S_WALK_WAIT,
    S_FINISH,
    S_FINISH_WAIT,
    S_EMIT
  } state_t;

  function automatic logic is_digit(input logic [TOKEN_W-1:0] tok);
    return (tok >= CH_ZERO) && (tok <= CH_NINE);
  endfunction

  function automatic logic is_oper(input logic [TOKEN_W-1:0] tok);
    return (tok == CH_PLUS) || (tok == CH_MINUS) || (tok == CH_STAR) || (tok == CH_SLASH);
  endfunction

endpackage

// ----- hw/rtl/see_if.sv -----
// ----------------------------------------------------------------------------
// see_if: channel interfaces of the stack expression evaluator
// Token input, result output and the notation mode write channel.
// ----------------------------------------------------------------------------
interface see_tok_if;
  logic                           valid;
  logic                           ready;
  logic [see_pkg::TOKEN_W-1:0]    token;
  logic                           last;
  modport source (output valid, token, last, input ready);
  modport sink   (input valid, token, last, output ready);
endinterface

interface see_res_if;
  logic                               valid;
  logic                               ready;
  logic signed [see_pkg::VALUE_W-1:0] value;
  logic [see_pkg::STATUS_W-1:0]       status;
  modport source (output valid, value, status, input ready);
  modport sink   (input valid, value, status, output ready);
endinterface

interface see_cfg_if;
  logic valid;
  logic ready;
  logic notation_mode;
  modport source (output valid, notation_mode, input ready);
  modport sink   (input valid, notation_mode, output ready);
endinterface

// ----- hw/rtl/stack_expression_evaluator_core.sv -----
// ----------------------------------------------------------------------------
// stack_expression_evaluator_core: postfix / prefix expression evaluator
// Evaluates single digit expressions with + - * / on a value stack, one
// character per item, and returns the top of stack with a status.
// ----------------------------------------------------------------------------
//
//  Channel    Direction  Payload                    Accepted when
//  ---------  ---------  -------------------------  ---------------------------
//  tokens     in         token[7:0], last           tokens.valid & tokens.ready
//  results    out        value[31:0] s, status[2:0] results.valid & results.ready
//  mode_cfg   in         notation_mode              mode_cfg.valid (always ready)
//
//  A postfix digit or ignored character goes through idle, evaluate and
//  after; + - and * also read top and deeper value via the one stack RAM
//  read port, operate and write back; a divide adds the 32-step restoring
//  divider. A prefix item is buffered; the last one starts a back-to-front
//  walk of the buffer, each character going through its postfix states
//  with a buffer read state for idle. The result goes through finish,
//  finish wait and emit. Reset (rst, synchronous) empties the stack and
//  the buffer through their pointers; no clearing pass is needed. A stalled
//  result register only holds the sequencer when the next result is ready.
//
module stack_expression_evaluator_core (
  input  logic       clk,
  input  logic       rst,
  see_tok_if.sink    tokens,
  see_res_if.source  results,
  see_cfg_if.sink    mode_cfg
);

  // Sequencer and expression state.
  see_pkg::state_t                 state;
  see_pkg::state_t                 state_next;
  logic                            mode;
  logic [see_pkg::TOKEN_W-1:0]     tok;
  logic                            last_q;
  logic                            walking;
  logic [see_pkg::SP_W-1:0]        sp;
  logic [see_pkg::CNT_W-1:0]       count;
  logic [see_pkg::CNT_W-1:0]       idx;
  logic [see_pkg::STATUS_W-1:0]    err;
  logic [see_pkg::VALUE_W-1:0]     top_q;
  logic [see_pkg::VALUE_W-1:0]     res;

  // Iterative divider registers.
  logic [see_pkg::VALUE_W-1:0]     div_rem;
  logic [see_pkg::VALUE_W-1:0]     div_q;
  logic [see_pkg::VALUE_W-1:0]     div_dvs;
  logic                            div_neg;
  logic [see_pkg::DIV_CW-1:0]      div_cnt;
  logic                            op_div;

  // Result register.
  logic                            out_valid;
  logic [see_pkg::VALUE_W-1:0]     out_value;
  logic [see_pkg::STATUS_W-1:0]    out_status;

  // Memory ports.
  logic                            st_we;
  logic [see_pkg::SA_W-1:0]        st_waddr;
  logic [see_pkg::VALUE_W-1:0]     st_wdata;
  logic [see_pkg::SA_W-1:0]        st_raddr;
  logic [see_pkg::VALUE_W-1:0]     st_rdata;
  logic                            bf_we;
  logic [see_pkg::BA_W-1:0]        bf_raddr;
  logic [see_pkg::TOKEN_W-1:0]     bf_rdata;

  // Datapath helpers.
  logic [see_pkg::SP_W-1:0]        sp_m1;
  logic [see_pkg::SP_W-1:0]        sp_m2;
  logic [see_pkg::CNT_W-1:0]       idx_m1;
  logic [see_pkg::VALUE_W-1:0]     opa;
  logic [see_pkg::VALUE_W-1:0]     opb;
  logic [see_pkg::VALUE_W-1:0]     mul_lo;
  logic [see_pkg::VALUE_W:0]       div_trial;
  logic [see_pkg::VALUE_W:0]       div_diff;
  logic [see_pkg::VALUE_W-1:0]     div_res;
  logic                            accept;
  logic                            out_free;
  logic                            buf_full;
  logic [see_pkg::STATUS_W-1:0]    fin_status;

  assign sp_m1  = sp - see_pkg::SP_W'(1);
  assign sp_m2  = sp - see_pkg::SP_W'(2);
  assign idx_m1 = idx - see_pkg::CNT_W'(1);

  assign accept   = tokens.valid && tokens.ready;
  assign out_free = !out_valid || results.ready;
  assign buf_full = count >= see_pkg::CNT_W'(see_pkg::EXPR_MAX);

  // Operand order: postfix takes the deeper value as the left operand, the
  // reversed prefix walk takes the top as the left operand. The deeper value
  // arrives from the stack RAM in the operate state.
  assign opa = walking ? top_q : st_rdata;
  assign opb = walking ? st_rdata : top_q;

  assign mul_lo = see_pkg::VALUE_W'(opa * opb);

  // One restoring division step per cycle on magnitudes.
  assign div_trial = {div_rem, div_q[see_pkg::VALUE_W-1]};
  assign div_diff  = div_trial - {1'b0, div_dvs};
  assign div_res   = div_neg ? (see_pkg::VALUE_W'(0) - div_q) : div_q;

  // An empty stack at the end reports an underflow.
  assign fin_status = (err != see_pkg::ST_OK) ? err :
                      (sp == '0) ? see_pkg::ST_UNDERFLOW : see_pkg::ST_OK;

  assign tokens.ready   = (state == see_pkg::S_IDLE);
  assign mode_cfg.ready = 1'b1;
  assign results.valid  = out_valid;
  assign results.value  = out_value;
  assign results.status = out_status;

  see_ram #(.WIDTH(see_pkg::VALUE_W), .DEPTH(see_pkg::STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  see_ram #(.WIDTH(see_pkg::TOKEN_W), .DEPTH(see_pkg::EXPR_MAX)) u_buffer (
    .clk   (clk),
    .we    (bf_we),
    .waddr (count[see_pkg::BA_W-1:0]),
    .wdata (tokens.token),
    .raddr (bf_raddr),
    .rdata (bf_rdata)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      see_pkg::S_IDLE: begin
        if (accept) begin
          if (mode) begin
            state_next = tokens.last ? see_pkg::S_AFTER : see_pkg::S_IDLE;
          end else begin
            state_next = see_pkg::S_EVAL;
          end
        end
      end
      see_pkg::S_EVAL: begin
        if (err != see_pkg::ST_OK || see_pkg::is_digit(tok) || !see_pkg::is_oper(tok) ||
            sp < see_pkg::SP_W'(2)) begin
          state_next = see_pkg::S_AFTER;
        end else begin
          state_next = see_pkg::S_RD_TOP;
        end
      end
      see_pkg::S_RD_TOP:  state_next = see_pkg::S_RD_DEEP;
      see_pkg::S_RD_DEEP: state_next = see_pkg::S_OPER;
      see_pkg::S_OPER: begin
        if (tok == see_pkg::CH_SLASH) begin
          state_next = (opb == '0) ? see_pkg::S_AFTER : see_pkg::S_DIV;
        end else begin
          state_next = see_pkg::S_WRITE;
        end
      end
      see_pkg::S_DIV: begin
        if (div_cnt == see_pkg::DIV_CW'(see_pkg::VALUE_W - 1)) begin
          state_next = see_pkg::S_WRITE;
        end
      end
      see_pkg::S_WRITE: state_next = see_pkg::S_AFTER;
      see_pkg::S_AFTER: begin
        if (walking && err == see_pkg::ST_OK && idx != '0) begin
          state_next = see_pkg::S_WALK_WAIT;
        end else if (last_q) begin
          state_next = see_pkg::S_FINISH;
        end else begin
          state_next = see_pkg::S_IDLE;
        end
      end
      see_pkg::S_WALK_WAIT:   state_next = see_pkg::S_EVAL;
      see_pkg::S_FINISH:      state_next = see_pkg::S_FINISH_WAIT;
      see_pkg::S_FINISH_WAIT: state_next = see_pkg::S_EMIT;
      see_pkg::S_EMIT: begin
        if (out_free) begin
          state_next = see_pkg::S_IDLE;
        end
      end
      default: state_next = see_pkg::S_IDLE;
    endcase
  end

  // Memory controls.
  always_comb begin
    st_we    = 1'b0;
    st_waddr = sp[see_pkg::SA_W-1:0];
    st_wdata = see_pkg::VALUE_W'(tok - see_pkg::CH_ZERO);
    st_raddr = sp_m1[see_pkg::SA_W-1:0];
    bf_we    = 1'b0;
    bf_raddr = idx_m1[see_pkg::BA_W-1:0];
    unique case (state)
      see_pkg::S_IDLE: begin
        bf_we = accept && mode && err == see_pkg::ST_OK && !buf_full;
      end
      see_pkg::S_EVAL: begin
        st_we = err == see_pkg::ST_OK && see_pkg::is_digit(tok) &&
                sp < see_pkg::SP_W'(see_pkg::STACK_DEPTH);
      end
      see_pkg::S_RD_DEEP: begin
        st_raddr = sp_m2[see_pkg::SA_W-1:0];
      end
      see_pkg::S_WRITE: begin
        st_we    = 1'b1;
        st_waddr = sp_m2[see_pkg::SA_W-1:0];
        st_wdata = op_div ? div_res : res;
      end
      default: begin
      end
    endcase
  end

  // Registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= see_pkg::S_IDLE;
      mode      <= 1'b0;
      sp        <= '0;
      count     <= '0;
      err       <= see_pkg::ST_OK;
      walking   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (mode_cfg.valid) begin
        mode <= mode_cfg.notation_mode;
      end

      if (out_valid && results.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        see_pkg::S_IDLE: begin
          if (accept) begin
            tok    <= tokens.token;
            last_q <= tokens.last;
            if (mode) begin
              // Prefix characters go to the buffer; the walk starts on last.
              if (err == see_pkg::ST_OK) begin
                if (buf_full) begin
                  err <= see_pkg::ST_BUFFULL;
                end else begin
                  count <= count + see_pkg::CNT_W'(1);
                end
              end
              walking <= tokens.last;
              idx     <= (err == see_pkg::ST_OK && !buf_full) ?
                         count + see_pkg::CNT_W'(1) : count;
            end else begin
              walking <= 1'b0;
            end
          end
        end
        see_pkg::S_EVAL: begin
          if (err == see_pkg::ST_OK) begin
            if (see_pkg::is_digit(tok)) begin
              if (sp < see_pkg::SP_W'(see_pkg::STACK_DEPTH)) begin
                sp <= sp + see_pkg::SP_W'(1);
              end else begin
                err <= see_pkg::ST_OVERFLOW;
              end
            end else if (see_pkg::is_oper(tok) && sp < see_pkg::SP_W'(2)) begin
              err <= see_pkg::ST_UNDERFLOW;
            end
          end
        end
        see_pkg::S_RD_DEEP: begin
          top_q <= st_rdata;
        end
        see_pkg::S_OPER: begin
          op_div <= (tok == see_pkg::CH_SLASH);
          priority case (tok)
            see_pkg::CH_PLUS:  res <= opa + opb;
            see_pkg::CH_MINUS: res <= opa - opb;
            see_pkg::CH_STAR:  res <= mul_lo;
            default: begin
              if (opb == '0) begin
                err <= see_pkg::ST_DIVZERO;
              end
            end
          endcase
          // Load the divider with the operand magnitudes.
          div_rem <= '0;
          div_q   <= opa[see_pkg::VALUE_W-1] ? (see_pkg::VALUE_W'(0) - opa) : opa;
          div_dvs <= opb[see_pkg::VALUE_W-1] ? (see_pkg::VALUE_W'(0) - opb) : opb;
          div_neg <= opa[see_pkg::VALUE_W-1] ^ opb[see_pkg::VALUE_W-1];
          div_cnt <= '0;
        end
        see_pkg::S_DIV: begin
          if (!div_diff[see_pkg::VALUE_W]) begin
            div_rem <= div_diff[see_pkg::VALUE_W-1:0];
            div_q   <= {div_q[see_pkg::VALUE_W-2:0], 1'b1};
          end else begin
            div_rem <= div_trial[see_pkg::VALUE_W-1:0];
            div_q   <= {div_q[see_pkg::VALUE_W-2:0], 1'b0};
          end
          div_cnt <= div_cnt + see_pkg::DIV_CW'(1);
        end
        see_pkg::S_WRITE: begin
          sp <= sp_m1;
        end
        see_pkg::S_AFTER: begin
          if (walking && err == see_pkg::ST_OK && idx != '0) begin
            idx <= idx_m1;
          end
        end
        see_pkg::S_WALK_WAIT: begin
          tok <= bf_rdata;
        end
        see_pkg::S_FINISH_WAIT: begin
          top_q <= st_rdata;
        end
        see_pkg::S_EMIT: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_status <= fin_status;
            out_value  <= (fin_status == see_pkg::ST_OK) ? top_q : '0;
            sp         <= '0;
            count      <= '0;
            err        <= see_pkg::ST_OK;
            walking    <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/see_ram.sv -----
// ----------------------------------------------------------------------------
// see_ram: generic single write port, single read port RAM
// The read data is registered: it appears in the cycle after the address.
// ----------------------------------------------------------------------------
module see_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
